// File: src/bsp_pkg.sv
// Shared types, constants and helper functions for the billboard sprite projector.
// Used by every module of the block; no dependencies.
package bsp_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int DIR_FRAC      = 14;
  localparam int IN_W          = 184;
  localparam int OUT_W         = 104;
  localparam int DIV_NUM_W     = 64;
  localparam int DIV_DEN_W     = 34;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_W = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_H = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TEX_W    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TEX_H    = 2'd3;

  localparam logic [11:0] SCREEN_W_RST = 12'd640;
  localparam logic [11:0] SCREEN_H_RST = 12'd480;
  localparam logic [10:0] TEX_RST      = 11'd64;
  localparam logic [10:0] TEX_LIMIT    = 11'd1024;
  localparam logic [15:0] SIZE_MAX     = 16'hFFFF;

  typedef enum logic [4:0] {
    OP_NOP, OP_LOAD, OP_DET0, OP_DET1, OP_DET2, OP_NX1, OP_NX2, OP_DIV_TX,
    OP_NY1, OP_NY2, OP_WAIT_TX, OP_DIV_TY, OP_WAIT_TY, OP_ZERO, OP_STORE0,
    OP_CMUL, OP_DIV_C, OP_WAIT_C, OP_DIV_S, OP_WAIT_S, OP_BOX, OP_QEVAL,
    OP_DIV_QX, OP_WAIT_QX, OP_DIV_QY, OP_WAIT_QY, OP_QRES, OP_OUT
  } op_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DET0, ST_DET1, ST_DET2, ST_NX1, ST_NX2, ST_DIVTX, ST_NY1,
    ST_NY2, ST_WTX, ST_DIVTY, ST_WTY, ST_ZERO, ST_CHK, ST_STORE0, ST_CMUL,
    ST_DIVC, ST_WC, ST_DIVS, ST_WS, ST_BOX, ST_QEVAL, ST_DIVQX, ST_WQX,
    ST_DIVQY, ST_WQY, ST_QRES, ST_OUT
  } state_t;

  typedef struct packed {
    logic det_zero;
    logic ty_pos;
    logic hit;
    logic div_done;
    logic out_free;
  } status_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic [11:0] clamp_coord(input logic signed [33:0] v,
                                              input logic [11:0] hi);
    if (v < 34'sd0) return 12'd0;
    if (v > $signed({22'd0, hi})) return hi;
    return v[11:0];
  endfunction

  function automatic logic [9:0] tex_clamp(input logic signed [63:0] q,
                                           input logic [10:0] t);
    logic [10:0] top;
    top = ((t > TEX_LIMIT) ? TEX_LIMIT : t) - 11'd1;
    if (t == 11'd0) return 10'd0;
    if (q < 64'sd0) return 10'd0;
    if (q > $signed({53'd0, top})) return top[9:0];
    return q[9:0];
  endfunction

endpackage

// File: src/bsp_div.sv
// Shared radix-2 restoring signed divider, truncating toward zero.
// Depends on bsp_pkg.
module bsp_div (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [bsp_pkg::DIV_NUM_W-1:0] num,
  input  logic signed [bsp_pkg::DIV_DEN_W-1:0] den,
  output logic                                done,
  output logic signed [bsp_pkg::DIV_NUM_W-1:0] quo
);
  import bsp_pkg::*;

  localparam int CNT_W = $clog2(DIV_NUM_W);

  logic [DIV_NUM_W-1:0] work;
  logic [DIV_DEN_W:0]   rem;
  logic [DIV_DEN_W-1:0] dmag;
  logic [CNT_W-1:0]     cnt;
  logic                 neg;
  logic                 busy;

  logic [DIV_DEN_W:0]   rem_sh;
  logic                 ge;
  logic [DIV_DEN_W:0]   rem_next;
  logic [DIV_NUM_W-1:0] work_next;

  always_comb begin
    rem_sh    = {rem[DIV_DEN_W-1:0], work[DIV_NUM_W-1]};
    ge        = rem_sh >= {1'b0, dmag};
    rem_next  = ge ? rem_sh - {1'b0, dmag} : rem_sh;
    work_next = {work[DIV_NUM_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        work <= num[DIV_NUM_W-1] ? $unsigned(-num) : $unsigned(num);
        dmag <= den[DIV_DEN_W-1] ? $unsigned(-den) : $unsigned(den);
        rem  <= '0;
        neg  <= num[DIV_NUM_W-1] ^ den[DIV_DEN_W-1];
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        rem  <= rem_next;
        work <= work_next;
        cnt  <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(DIV_NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
          quo  <= neg ? -$signed(work_next) : $signed(work_next);
        end
      end
    end
  end

endmodule

// File: src/bsp_ctrl.sv
// Sequencer for setup and query items; issues one datapath op per cycle.
// Depends on bsp_pkg.
module bsp_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_query,
  input  bsp_pkg::status_t stat,
  output logic             in_ready,
  output bsp_pkg::op_t     op
);
  import bsp_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    op         = OP_NOP;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op         = OP_LOAD;
          state_next = in_query ? ST_QEVAL : ST_DET0;
        end
      end
      ST_DET0: begin op = OP_DET0; state_next = ST_DET1; end
      ST_DET1: begin op = OP_DET1; state_next = ST_DET2; end
      ST_DET2: begin op = OP_DET2; state_next = ST_NX1; end
      ST_NX1:  begin op = OP_NX1;  state_next = ST_NX2; end
      ST_NX2: begin
        op         = OP_NX2;
        state_next = stat.det_zero ? ST_ZERO : ST_DIVTX;
      end
      ST_DIVTX: begin op = OP_DIV_TX; state_next = ST_NY1; end
      ST_NY1:   begin op = OP_NY1;    state_next = ST_NY2; end
      ST_NY2:   begin op = OP_NY2;    state_next = ST_WTX; end
      ST_WTX: begin
        op = OP_WAIT_TX;
        if (stat.div_done) state_next = ST_DIVTY;
      end
      ST_DIVTY: begin op = OP_DIV_TY; state_next = ST_WTY; end
      ST_WTY: begin
        op = OP_WAIT_TY;
        if (stat.div_done) state_next = ST_CHK;
      end
      ST_ZERO: begin op = OP_ZERO; state_next = ST_CHK; end
      ST_CHK: begin
        state_next = stat.ty_pos ? ST_CMUL : ST_STORE0;
      end
      ST_STORE0: begin op = OP_STORE0; state_next = ST_OUT; end
      ST_CMUL:   begin op = OP_CMUL;   state_next = ST_DIVC; end
      ST_DIVC:   begin op = OP_DIV_C;  state_next = ST_WC; end
      ST_WC: begin
        op = OP_WAIT_C;
        if (stat.div_done) state_next = ST_DIVS;
      end
      ST_DIVS: begin op = OP_DIV_S; state_next = ST_WS; end
      ST_WS: begin
        op = OP_WAIT_S;
        if (stat.div_done) state_next = ST_BOX;
      end
      ST_BOX: begin op = OP_BOX; state_next = ST_OUT; end
      ST_QEVAL: begin op = OP_QEVAL; state_next = ST_DIVQX; end
      ST_DIVQX: begin
        if (stat.hit) begin
          op         = OP_DIV_QX;
          state_next = ST_WQX;
        end else begin
          state_next = ST_OUT;
        end
      end
      ST_WQX: begin
        op = OP_WAIT_QX;
        if (stat.div_done) state_next = ST_DIVQY;
      end
      ST_DIVQY: begin op = OP_DIV_QY; state_next = ST_WQY; end
      ST_WQY: begin
        op = OP_WAIT_QY;
        if (stat.div_done) state_next = ST_QRES;
      end
      ST_QRES: begin op = OP_QRES; state_next = ST_OUT; end
      ST_OUT: begin
        if (stat.out_free) begin
          op         = OP_OUT;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// File: src/bsp_datapath.sv
// Datapath: config registers, multiplier, divider, sprite state and output register.
// Depends on bsp_pkg and bsp_div.
module bsp_datapath #(
  parameter int FRAC_BITS = bsp_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  bsp_pkg::op_t                    op,
  output bsp_pkg::status_t                stat,
  input  logic [bsp_pkg::IN_W-1:0]        in_data,
  input  logic                            cfg_we,
  input  logic [bsp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bsp_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [bsp_pkg::OUT_W-1:0]       out_data
);
  import bsp_pkg::*;

  logic [11:0] sw, sh;
  logic [10:0] tw, th;

  logic signed [15:0] dx, dy, px, py;
  logic signed [31:0] rx, ry;
  logic [11:0]        pix_x, pix_y;
  logic [30:0]        wall;

  logic signed [47:0] prod;
  logic signed [48:0] acc;
  logic signed [32:0] det;
  logic signed [31:0] tx, ty;

  logic signed [31:0] sp_depth, sp_ctr;
  logic [15:0]        sp_size;
  logic [11:0]        bsx, bex, bsy, bey;

  logic               hit;
  logic [16:0]        offx;
  logic signed [17:0] offy;
  logic [9:0]         texx;
  logic [OUT_W-1:0]   res;

  logic signed [15:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [47:0] prod_new;
  logic signed [32:0] tsum;
  logic signed [44:0] cmul;

  logic                        div_start;
  logic signed [DIV_NUM_W-1:0] div_num;
  logic signed [DIV_DEN_W-1:0] div_den;
  logic                        div_done;
  logic signed [DIV_NUM_W-1:0] div_quo;
  logic [27:0]                 qx_prod;
  logic signed [29:0]          qy_prod;

  logic [15:0]        sz_q;
  logic [14:0]        hs;
  logic signed [33:0] ctr_e;
  logic [11:0]        n_bsx, n_bex, n_bsy, n_bey;

  logic               q_hit;
  logic signed [33:0] offx_full;
  logic signed [17:0] hdiff, hhalf;

  bsp_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (op)
      OP_DET0: begin mul_a = px; mul_b = 32'(dy); end
      OP_DET1: begin mul_a = dx; mul_b = 32'(py); end
      OP_DET2: begin mul_a = dy; mul_b = rx; end
      OP_NX1:  begin mul_a = dx; mul_b = ry; end
      OP_NX2:  begin mul_a = px; mul_b = ry; end
      OP_NY1:  begin mul_a = py; mul_b = rx; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
    prod_new = mul_a * mul_b;
    tsum     = {ty[31], ty} + {tx[31], tx};
    cmul     = $signed({1'b0, sw[11:1]}) * tsum;
  end

  // divider operands
  always_comb begin
    qx_prod   = offx * tw;
    qy_prod   = offy * $signed({1'b0, th});
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    case (op)
      OP_DIV_TX, OP_DIV_TY: begin
        div_start = 1'b1;
        div_num   = {acc[48], acc, {DIR_FRAC{1'b0}}};
        div_den   = {det[32], det};
      end
      OP_DIV_C: begin
        div_start = 1'b1;
        div_num   = {{15{acc[48]}}, acc};
        div_den   = {{2{ty[31]}}, ty};
      end
      OP_DIV_S: begin
        div_start = 1'b1;
        div_num   = $signed({52'd0, sh} << FRAC_BITS);
        div_den   = {{2{ty[31]}}, ty};
      end
      OP_DIV_QX: begin
        div_start = 1'b1;
        div_num   = $signed({36'd0, qx_prod});
        div_den   = {18'd0, sp_size};
      end
      OP_DIV_QY: begin
        div_start = 1'b1;
        div_num   = {{34{qy_prod[29]}}, qy_prod};
        div_den   = {18'd0, sp_size};
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  // box from center and size
  always_comb begin
    sz_q  = (div_quo > 64'sd65535) ? SIZE_MAX : div_quo[15:0];
    hs    = sz_q[15:1];
    ctr_e = {{2{sp_ctr[31]}}, sp_ctr};
    n_bsy = clamp_coord($signed({23'd0, sh[11:1]}) - $signed({19'd0, hs}), sh);
    n_bey = clamp_coord($signed({23'd0, sh[11:1]}) + $signed({19'd0, hs}), sh);
    n_bsx = clamp_coord(ctr_e - $signed({19'd0, hs}), sw);
    n_bex = clamp_coord(ctr_e + $signed({19'd0, hs}), sw);
  end

  // query coverage
  always_comb begin
    q_hit = (sp_depth > 32'sd0) && (sp_size != 16'd0)
         && (pix_x >= bsx) && (pix_x < bex)
         && (pix_y >= bsy) && (pix_y < bey)
         && ($unsigned(sp_depth) < {1'b0, wall})
         && (pix_x != 12'd0) && (pix_x < sw);
    offx_full = $signed({22'd0, pix_x}) - (ctr_e - $signed({19'd0, sp_size[15:1]}));
    hdiff     = $signed({6'd0, sh}) - $signed({2'd0, sp_size});
    hhalf     = (hdiff + $signed({17'd0, hdiff[17]})) >>> 1;
  end

  assign stat.det_zero = (det == 33'sd0);
  assign stat.ty_pos   = (ty > 32'sd0);
  assign stat.hit      = hit;
  assign stat.div_done = div_done;
  assign stat.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sw       <= SCREEN_W_RST;
      sh       <= SCREEN_H_RST;
      tw       <= TEX_RST;
      th       <= TEX_RST;
      sp_depth <= '0;
      sp_ctr   <= '0;
      sp_size  <= '0;
      bsx      <= '0;
      bex      <= '0;
      bsy      <= '0;
      bey      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SCREEN_W: sw <= cfg_data;
          CFG_SCREEN_H: sh <= cfg_data;
          CFG_TEX_W:    tw <= cfg_data[10:0];
          CFG_TEX_H:    th <= cfg_data[10:0];
          default:      sw <= sw;
        endcase
      end

      case (op)
        OP_LOAD: begin
          dx    <= in_data[15:0];
          dy    <= in_data[31:16];
          px    <= in_data[47:32];
          py    <= in_data[63:48];
          rx    <= in_data[95:64];
          ry    <= in_data[127:96];
          pix_x <= in_data[139:128];
          pix_y <= in_data[151:140];
          wall  <= in_data[182:152];
        end
        OP_DET0: prod <= prod_new;
        OP_DET1, OP_NX1, OP_NY1: begin
          acc  <= {prod[47], prod};
          prod <= prod_new;
        end
        OP_DET2: begin
          det  <= 33'(acc - {prod[47], prod});
          prod <= prod_new;
        end
        OP_NX2: begin
          acc  <= acc - {prod[47], prod};
          prod <= prod_new;
        end
        OP_NY2: acc <= acc - {prod[47], prod};
        OP_WAIT_TX: if (div_done) tx <= sat32(div_quo);
        OP_WAIT_TY: if (div_done) ty <= sat32(div_quo);
        OP_ZERO: begin
          tx <= '0;
          ty <= '0;
        end
        OP_STORE0: begin
          sp_depth <= ty;
          sp_ctr   <= '0;
          sp_size  <= '0;
          bsx      <= '0;
          bex      <= '0;
          bsy      <= '0;
          bey      <= '0;
          res      <= {71'd0, ty, 1'b0};
        end
        OP_CMUL: acc <= {{4{cmul[44]}}, cmul};
        OP_WAIT_C: if (div_done) sp_ctr <= sat32(div_quo);
        OP_BOX: begin
          sp_depth <= ty;
          sp_size  <= sz_q;
          bsx      <= n_bsx;
          bex      <= n_bex;
          bsy      <= n_bsy;
          bey      <= n_bey;
          res      <= {23'd0, n_bey, n_bsy, n_bex, n_bsx, ty, (sz_q != 16'd0)};
        end
        OP_QEVAL: begin
          hit  <= q_hit;
          offx <= offx_full[16:0];
          offy <= $signed({6'd0, pix_y}) - hhalf;
          res  <= '0;
        end
        OP_WAIT_QX: if (div_done) texx <= tex_clamp(div_quo, tw);
        OP_WAIT_QY: begin
          if (div_done) begin
            res <= {2'd0, tex_clamp(div_quo, th), texx, 1'b1, 81'd0};
          end
        end
        OP_OUT: begin
          out_valid <= 1'b1;
          out_data  <= res;
        end
        default: ;
      endcase

      if (op != OP_OUT && out_valid && out_ready) out_valid <= 1'b0;
    end
  end

endmodule

// File: src/billboard_sprite_projector.sv
// Billboard sprite projector top level: sequencer plus datapath.
// Depends on bsp_pkg, bsp_ctrl, bsp_datapath.
//
// Takes one item at a time. A setup beat projects the sprite through the inverse camera
// matrix and stores its depth, center column, size and clipped box, using up to four
// divisions on the one shared bit-serial divider (lateral offset, depth, center column,
// size). A query beat uses two divisions for the texture coordinates when it hits and
// none when it misses. Results sit in an output register, so the next beat is taken while a
// result waits. Configuration writes are always accepted and must only happen when idle.
module billboard_sprite_projector #(
  parameter int FRAC_BITS = bsp_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // dir_x, dir_y, plane_x, plane_y, rel_x, rel_y, pixel_x, pixel_y, wall_depth, pad
  input  logic [bsp_pkg::IN_W-1:0]       s_tdata,
  // req_type
  input  logic [0:0]                     s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // visible, depth, start_x, end_x, start_y, end_y, draw, tex_x, tex_y, pad
  output logic [bsp_pkg::OUT_W-1:0]      m_tdata,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bsp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bsp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bsp_pkg::*;

  op_t     op;
  status_t stat;

  assign cfg_ready = 1'b1;

  bsp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_query (s_tuser[0]),
    .stat     (stat),
    .in_ready (s_tready),
    .op       (op)
  );

  bsp_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .op        (op),
    .stat      (stat),
    .in_data   (s_tdata),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

endmodule

// File: src/bsp_checker.sv
// Port-level checks for the billboard sprite projector, bound to the top level.
// Depends on bsp_pkg and billboard_sprite_projector.
module bsp_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [bsp_pkg::OUT_W-1:0]      m_tdata
);
  import bsp_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result beat dropped while stalled");

  a_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[0] && m_tdata[81]))
    else $error("beat flags both setup and query result");

  a_box: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> (m_tdata[44:33] <= m_tdata[56:45])
                            && (m_tdata[68:57] <= m_tdata[80:69]))
    else $error("visible sprite with inverted box");

  a_depth: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> !m_tdata[32] && (m_tdata[32:1] != 32'd0))
    else $error("visible sprite with nonpositive depth");

endmodule

bind billboard_sprite_projector bsp_checker u_bsp_checker (.*);

// File: sim/billboard_sprite_projector_tb.sv
// Testbench for billboard_sprite_projector: directed and random setup and query beats,
// checked against a behavioral predictor of the sprite projection. Needs bsp_pkg and the RTL.
module billboard_sprite_projector_tb;
  import bsp_pkg::*;

  localparam int LIMIT = 3000000;
  localparam int DRAIN = 400;

  typedef struct {
    bit        visible;
    bit [31:0] depth;
    bit [11:0] start_x, end_x, start_y, end_y;
    bit        draw;
    bit [9:0]  tex_x, tex_y;
  } proj_res_t;

  logic clk, rst;
  logic s_tvalid, s_tready, m_tvalid, m_tready;
  logic [IN_W-1:0] s_tdata;
  logic [0:0] s_tuser;
  logic [OUT_W-1:0] m_tdata;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  billboard_sprite_projector uut (.*);

  // predictor state
  longint scr_w, scr_h, tex_w, tex_h;
  longint spr_depth, spr_ctr, spr_size, bsx, bex, bsy, bey;

  proj_res_t pending[$];
  int errors, n_setup, n_query, n_draw, n_vis, cycles;
  bit quiet;
  int stall_left;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(negedge clk) begin
    if (stall_left > 0) begin
      m_tready = 0;
      stall_left--;
    end else begin
      m_tready = 1;
      stall_left = pick_gap();
    end
  end

  task automatic report(string what, longint got, longint want);
    $display("ERROR %s: got %0h expected %0h", what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    proj_res_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (pending.size() == 0) report("unexpected beat", m_tdata[31:0], 0);
      else begin
        e = pending.pop_front();
        if (m_tdata[0] !== e.visible) report("visible", m_tdata[0], e.visible);
        if (m_tdata[32:1] !== e.depth) report("depth", m_tdata[32:1], e.depth);
        if (m_tdata[44:33] !== e.start_x) report("start_x", m_tdata[44:33], e.start_x);
        if (m_tdata[56:45] !== e.end_x) report("end_x", m_tdata[56:45], e.end_x);
        if (m_tdata[68:57] !== e.start_y) report("start_y", m_tdata[68:57], e.start_y);
        if (m_tdata[80:69] !== e.end_y) report("end_y", m_tdata[80:69], e.end_y);
        if (m_tdata[81] !== e.draw) report("draw", m_tdata[81], e.draw);
        if (m_tdata[91:82] !== e.tex_x) report("tex_x", m_tdata[91:82], e.tex_x);
        if (m_tdata[101:92] !== e.tex_y) report("tex_y", m_tdata[101:92], e.tex_y);
      end
    end
  end

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint clampl(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic bit [9:0] tex_coord(longint v, longint tsize);
    longint top;
    top = (tsize > 1024 ? 1024 : tsize) - 1;
    if (top < 0) return '0;
    return 10'(clampl(v, 0, top));
  endfunction

  function automatic proj_res_t project_sprite(longint dx, longint dy, longint px, longint py,
                                               longint rx, longint ry);
    proj_res_t r;
    longint det, tx, ty, hs, sz;
    r = '{default: 0};
    det = px * dy - dx * py;
    tx = 0;
    ty = 0;
    if (det != 0) begin
      tx = clip32(((dy * rx - dx * ry) * 16384) / det);
      ty = clip32(((px * ry - py * rx) * 16384) / det);
    end
    spr_depth = ty;
    spr_ctr = 0;
    spr_size = 0;
    bsx = 0; bex = 0; bsy = 0; bey = 0;
    if (ty > 0) begin
      spr_ctr = clip32(((scr_w / 2) * (ty + tx)) / ty);
      sz = (scr_h * 65536) / ty;
      if (sz > 65535) sz = 65535;
      hs = sz / 2;
      spr_size = sz;
      bsy = clampl(scr_h / 2 - hs, 0, scr_h);
      bey = clampl(scr_h / 2 + hs, 0, scr_h);
      bsx = clampl(spr_ctr - hs, 0, scr_w);
      bex = clampl(spr_ctr + hs, 0, scr_w);
    end
    r.visible = spr_depth > 0 && spr_size > 0;
    r.depth = spr_depth[31:0];
    r.start_x = bsx[11:0];
    r.end_x = bex[11:0];
    r.start_y = bsy[11:0];
    r.end_y = bey[11:0];
    return r;
  endfunction

  function automatic proj_res_t shade_pixel(longint x, longint y, longint wall);
    proj_res_t r;
    longint offx, offy;
    r = '{default: 0};
    if (spr_depth > 0 && spr_size > 0 && x >= bsx && x < bex && y >= bsy && y < bey &&
        spr_depth < wall && x > 0 && x < scr_w) begin
      offx = x - (spr_ctr - spr_size / 2);
      offy = y - (scr_h - spr_size) / 2;
      r.draw = 1;
      r.tex_x = tex_coord((offx * tex_w) / spr_size, tex_w);
      r.tex_y = tex_coord((offy * tex_h) / spr_size, tex_h);
    end
    return r;
  endfunction

  // drive one beat; entered and left on a falling edge
  task automatic send_beat(bit kind, logic [IN_W-1:0] data);
    proj_res_t e;
    s_tdata = data;
    s_tuser = kind;
    s_tvalid = 1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (kind == 1'b0) begin
      e = project_sprite($signed(data[15:0]), $signed(data[31:16]), $signed(data[47:32]),
                         $signed(data[63:48]), $signed(data[95:64]), $signed(data[127:96]));
      n_setup++;
      if (e.visible) n_vis++;
    end else begin
      e = shade_pixel(data[139:128], data[151:140], data[182:152]);
      n_query++;
      if (e.draw) n_draw++;
    end
    pending.push_back(e);
    @(negedge clk);
    s_tvalid = 0;
    repeat (pick_gap()) @(negedge clk);
  endtask

  task automatic send_setup(logic [15:0] dx, dy, px, py, logic [31:0] rx, ry);
    send_beat(1'b0, {56'd0, ry, rx, py, px, dy, dx});
  endtask

  task automatic send_query(logic [11:0] x, y, logic [30:0] wall);
    send_beat(1'b1, {1'b0, wall, y, x, 128'd0});
  endtask

  task automatic wait_idle();
    while (pending.size() != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_index = idx;
    cfg_data = val;
    cfg_valid = 1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_SCREEN_W: scr_w = val;
      CFG_SCREEN_H: scr_h = val;
      CFG_TEX_W:    tex_w = val[10:0];
      default:      tex_h = val[10:0];
    endcase
    @(negedge clk);
    cfg_valid = 0;
  endtask

  task automatic set_config(int w, int h, int tw, int th);
    wait_idle();
    write_reg(CFG_SCREEN_W, 12'(w));
    write_reg(CFG_SCREEN_H, 12'(h));
    write_reg(CFG_TEX_W, 12'(tw));
    write_reg(CFG_TEX_H, 12'(th));
  endtask

  // sprite in front of a camera looking along (c,s)
  task automatic random_view();
    int c, s;
    longint d, lat, rx, ry;
    c = $signed($urandom_range(0, 32768)) - 16384;
    s = $signed($urandom_range(0, 32768)) - 16384;
    if (c == 0 && s == 0) c = 16384;
    d = $urandom_range(8192, 1310720);
    lat = $signed($urandom_range(0, 1310720)) - 655360;
    rx = (c * d) / 16384 + (s * lat) / 16384;
    ry = (s * d) / 16384 - (c * lat) / 16384;
    send_setup(16'(c), 16'(s), 16'((s * 2) / 3), 16'(-(c * 2) / 3), 32'(rx), 32'(ry));
  endtask

  task automatic random_query();
    longint x, y, wall;
    int r;
    r = $urandom_range(0, 99);
    if (r < 80 && bex > bsx && bey > bsy) begin
      x = $urandom_range(bsx, bex - 1);
      y = $urandom_range(bsy, bey - 1);
    end else begin
      x = $urandom_range(0, 4095);
      y = $urandom_range(0, 4095);
    end
    r = $urandom_range(0, 99);
    if (r < 60) wall = clampl(spr_depth + $urandom_range(1, 1 << 20), 0, 32'h7FFFFFFF);
    else if (r < 80) wall = clampl(spr_depth - $urandom_range(0, 1 << 16), 0, 32'h7FFFFFFF);
    else wall = $urandom_range(0, 32'h7FFFFFFF);
    send_query(12'(x), 12'(y), 31'(wall));
  endtask

  task automatic test_reset_state();
    quiet = 1;
    send_query(12'd100, 12'd100, 31'h7FFFFFFF);
    send_query(12'd0, 12'd0, 31'd0);
  endtask

  task automatic test_setup_cases();
    send_setup(0, 0, 0, 0, 32'h0001_0000, 32'h0001_0000);            // singular camera
    send_setup(16384, 0, 0, 10923, -32'sh0005_0000, 0);              // behind camera
    send_query(12'd320, 12'd240, 31'h7FFFFFFF);
    send_setup(16384, 0, 0, 10923, 32'h0005_0000, 0);                // straight ahead
    send_query(12'd320, 12'd240, 31'h7FFFFFFF);
    send_query(12'd320, 12'd240, 31'h0004_0000);                     // wall nearer
    send_query(12'd320, 12'd240, 31'h0005_0000);                     // wall at sprite depth
    send_setup(16384, 0, 0, 10923, 32'h0000_8000, 0);                // clipped on all sides
    send_query(12'd0, 12'd240, 31'h7FFFFFFF);                        // column zero
    send_query(12'd1, 12'd0, 31'h7FFFFFFF);
    send_query(12'd639, 12'd479, 31'h7FFFFFFF);
    send_query(12'd4095, 12'd4095, 31'h7FFFFFFF);
    send_setup(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 32'h7FFFFFFF, 32'h80000000);
    send_setup(16'h0001, 16'h0000, 16'h0000, 16'h0001, 32'h7FFFFFFF, 32'h7FFFFFFF);
    send_setup(16384, 0, 0, 10923, 32'h0000_0001, 32'h7FFFFFFF);     // tiny depth, huge size
    send_query(12'd320, 12'd240, 31'h7FFFFFFF);
    send_setup(16384, 0, 0, 10923, 32'h7FFF_0000, 32'h0100_0000);    // far away, off to side
    send_query(12'd320, 12'd240, 31'h7FFFFFFF);
    quiet = 0;
  endtask

  task automatic test_random_phase(int items);
    int k, j, nq;
    k = 0;
    while (k < items) begin
      quiet = (k > items / 3 && k < items / 2);
      if ($urandom_range(0, 99) < 15) begin
        send_setup(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                   32'($urandom), 32'($urandom));
      end else random_view();
      k++;
      nq = $urandom_range(2, 8);
      for (j = 0; j < nq; j++) begin
        if ($urandom_range(0, 99) < 10)
          send_query(12'($urandom), 12'($urandom), 31'($urandom));
        else random_query();
      end
      k += nq;
    end
    quiet = 0;
  endtask

  initial begin
    rst = 1;
    s_tvalid = 0;
    s_tdata = '0;
    s_tuser = '0;
    cfg_valid = 0;
    cfg_index = '0;
    cfg_data = '0;
    m_tready = 0;
    stall_left = 0;
    quiet = 0;
    errors = 0;
    cycles = 0;
    n_setup = 0; n_query = 0; n_draw = 0; n_vis = 0;
    scr_w = 640; scr_h = 480; tex_w = 64; tex_h = 64;
    spr_depth = 0; spr_ctr = 0; spr_size = 0;
    bsx = 0; bex = 0; bsy = 0; bey = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 0;

    test_reset_state();
    test_setup_cases();
    test_random_phase(420);
    set_config(4095, 4095, 1024, 1024);
    test_random_phase(420);
    set_config(1, 1, 1, 1);
    test_random_phase(200);
    set_config($urandom_range(1, 4095), $urandom_range(1, 4095),
               $urandom_range(1, 1024), $urandom_range(1, 1024));
    test_random_phase(320);
    set_config(320, 200, 16, 1024);
    test_random_phase(390);

    wait_idle();
    $display("Covered %0d setup beats (%0d visible) and %0d queries (%0d drawn)",
             n_setup, n_vis, n_query, n_draw);
    $display("Screen and texture sizes at reset, both extremes and random values");
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
